@@ rtl/core/bgeq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-gain FIR equalizer package
// Sizes, register indexes and the control bundle of the shared MAC unit.
// ----------------------------------------------------------------------------
package bgeq_pkg;

    // data word and filter geometry
    localparam int DW    = 32;
    localparam int TAPS  = 99;
    localparam int BANDS = 4;

    // tap address, tap counter (0..TAPS), sweep counter (0..TAPS+1), band counter
    localparam int AW  = $clog2(TAPS);
    localparam int TW  = $clog2(TAPS + 1);
    localparam int CW  = $clog2(TAPS + 2);
    localparam int BW  = $clog2(BANDS + 1);

    // config bus: two 32-bit registers at byte offsets 0 and 4
    localparam int PAW = 3;
    localparam logic REG_START  = 1'b0;
    localparam logic REG_FILTER = 1'b1;

    // shared MAC control
    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } t_mac_ctrl;

endpackage

@@ rtl/core/bgeq_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equalizer input channel
// Valid/ready channel carrying one stream word and its end mark per item.
// ----------------------------------------------------------------------------
interface bgeq_in_if;
    import bgeq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] word;
    logic                 end_mark;

    modport source (output valid, output word, output end_mark, input ready);
    modport sink   (input valid, input word, input end_mark, output ready);
endinterface

@@ rtl/core/bgeq_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equalizer output channel
// Valid/ready channel carrying one filter result and its final flag per item.
// ----------------------------------------------------------------------------
interface bgeq_out_if;
    import bgeq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] filtered;
    logic                 final_res;

    modport source (output valid, output filtered, output final_res, input ready);
    modport sink   (input valid, input filtered, input final_res, output ready);
endinterface

@@ rtl/core/bgeq_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equalizer shared multiply-accumulate unit
// One registered 32x32 multiplier (low word kept) followed by a wrapping
// 32-bit accumulator. Used for coefficient scaling and for the FIR sweep.
// ----------------------------------------------------------------------------
module bgeq_mac (
    input  logic                   i_clk,
    input  bgeq_pkg::t_mac_ctrl    i_ctrl,
    input  logic [bgeq_pkg::DW-1:0] i_a,
    input  logic [bgeq_pkg::DW-1:0] i_b,
    output logic [bgeq_pkg::DW-1:0] o_prod,
    output logic [bgeq_pkg::DW-1:0] o_acc
);
    import bgeq_pkg::*;

    logic [DW-1:0]   r_prod;
    logic [DW-1:0]   r_acc;
    logic [2*DW-1:0] full_prod;

    // full product, low word is what wraps
    assign full_prod = i_a * i_b;

    // product register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= full_prod[DW-1:0];
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

@@ rtl/core/band_gain_fir_equalizer_top.sv @@
`timescale 1ns / 1ps
// Marker and gain items are taken in S_IN; a coefficient item is a read-modify-write
// of the coefficient memory through the shared multiplier. A sample item makes one
// MAC per tap over the single multiplier, plus memory read and multiply pipeline fill
// and the output, which waits for a free output register. The closing result is
// sent from S_FIN. Reset (synchronous, active low) returns to idle, markers to
// 0xBEEF/0xABBA; the delay line reads as zero via its fill count.
// ----------------------------------------------------------------------------
// Band-gain FIR equalizer top level
// Loads per-band gain-scaled coefficients into a coefficient memory, then runs
// a TAPS-tap FIR per sample over a circular delay-line memory, one tap a cycle.
// ----------------------------------------------------------------------------
module band_gain_fir_equalizer_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bgeq_in_if.sink                  i_in,
    bgeq_out_if.source               o_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [bgeq_pkg::PAW-1:0] paddr,
    input  logic [bgeq_pkg::DW-1:0]  pwdata,
    output logic [bgeq_pkg::DW-1:0]  prdata,
    output logic                     pready
);
    import bgeq_pkg::*;

    typedef enum logic [6:0] {
        S_IN   = 7'b0000001,
        S_LMUL = 7'b0000010,
        S_LADD = 7'b0000100,
        S_FWR  = 7'b0001000,
        S_FMAC = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LOAD   = 4'b0010,
        PH_WAIT   = 4'b0100,
        PH_FILTER = 4'b1000
    } t_phase;

    // config registers
    logic [DW-1:0] r_start, r_filt;

    // sequencer and stream state
    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [BW-1:0] r_band, n_band;
    logic [TW-1:0] r_tap, n_tap;
    logic [DW-1:0] r_gain, n_gain;
    logic [DW-1:0] r_held, n_held;
    logic [DW-1:0] r_word, n_word;
    logic          r_end, n_end;

    // delay line pointers and sweep
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [TW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_v1, n_v1;
    logic          r_z1, n_z1;
    logic          r_v2;

    // output register
    logic          r_ovalid, n_ovalid;
    logic [DW-1:0] r_ofilt, n_ofilt;
    logic          r_ofinal, n_ofinal;

    // memories
    logic [DW-1:0] coef_mem [TAPS];
    logic [DW-1:0] dl_mem [TAPS];
    logic [DW-1:0] r_coef_rd, r_dl_rd;
    logic          coef_we, dl_we;
    logic [AW-1:0] coef_ra, coef_wa;
    logic [DW-1:0] coef_wd;

    // misc
    logic          in_acc, out_free, issue;
    logic [DW-1:0] w_in;
    logic [TW-1:0] tap_m1;
    t_mac_ctrl     mac_ctrl;
    logic [DW-1:0] mac_a, mac_b, mac_prod, mac_acc;

    assign w_in     = i_in.word;
    assign in_acc   = i_in.valid && (r_state == S_IN);
    assign out_free = !r_ovalid || o_out.ready;
    assign tap_m1   = r_tap - TW'(1);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= DW'(32'hBEEF);
            r_filt  <= DW'(32'hABBA);
        end else if (psel && penable && pwrite) begin
            if (paddr[PAW-1] == REG_FILTER) begin
                r_filt <= pwdata;
            end else begin
                r_start <= pwdata;
            end
        end
    end

    assign prdata = (paddr[PAW-1] == REG_FILTER) ? r_filt : r_start;
    assign pready = 1'b1;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_band   = r_band;
        n_tap    = r_tap;
        n_gain   = r_gain;
        n_held   = r_held;
        n_word   = r_word;
        n_end    = r_end;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ofilt  = r_ofilt;
        n_ofinal = r_ofinal;
        issue    = 1'b0;
        coef_we  = 1'b0;
        dl_we    = 1'b0;
        coef_wd  = (r_band == '0) ? mac_prod : r_coef_rd + mac_prod;

        case (r_state)
            S_IN: begin
                if (i_in.valid) begin
                    n_word = w_in;
                    n_end  = i_in.end_mark;
                    case (r_phase)
                        PH_IDLE: begin
                            if (w_in == r_start) begin
                                n_phase = PH_LOAD;
                                n_band  = '0;
                                n_tap   = '0;
                            end
                            if (i_in.end_mark) begin
                                n_state = S_FIN;
                            end
                        end
                        PH_LOAD: begin
                            // end marks are ignored while loading
                            if (r_tap == '0) begin
                                n_gain = w_in;
                                n_tap  = TW'(1);
                            end else begin
                                n_state = S_LMUL;
                            end
                        end
                        PH_WAIT: begin
                            if (w_in == r_filt) begin
                                n_phase = PH_FILTER;
                            end
                            if (i_in.end_mark) begin
                                n_state = S_FIN;
                            end
                        end
                        PH_FILTER: begin
                            n_state = S_FWR;
                        end
                        default: begin
                            n_state = S_IN;
                        end
                    endcase
                end
            end
            S_LMUL: begin
                n_state = S_LADD;
            end
            S_LADD: begin
                // first band overwrites, later bands accumulate
                coef_we = 1'b1;
                n_tap   = r_tap + TW'(1);
                if (r_tap == TW'(TAPS)) begin
                    n_tap  = '0;
                    n_band = r_band + BW'(1);
                    if (r_band == BW'(BANDS - 1)) begin
                        n_phase = PH_WAIT;
                    end
                end
                n_state = S_IN;
            end
            S_FWR: begin
                // push sample at the write pointer, sweep starts at age zero
                dl_we = 1'b1;
                n_rp  = r_wp;
                n_wp  = (r_wp == AW'(TAPS - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != TW'(TAPS)) begin
                    n_fill = r_fill + TW'(1);
                end
                n_cnt   = '0;
                n_state = S_FMAC;
            end
            S_FMAC: begin
                issue = (r_cnt < CW'(TAPS));
                if (issue) begin
                    n_rp = (r_rp == '0) ? AW'(TAPS - 1) : r_rp - AW'(1);
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(TAPS + 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ofilt  = mac_acc;
                    n_ofinal = 1'b0;
                    n_held   = mac_acc;
                    n_state  = r_end ? S_FIN : S_IN;
                end
            end
            S_FIN: begin
                // closing copy, run ends
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ofilt  = r_held;
                    n_ofinal = 1'b1;
                    n_held   = '0;
                    n_phase  = PH_IDLE;
                    n_band   = '0;
                    n_tap    = '0;
                    n_state  = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // sweep pipeline flags; samples older than the fill count read as zero
    assign n_v1 = issue;
    assign n_z1 = issue && (r_cnt >= CW'(r_fill));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IN;
            r_phase  <= PH_IDLE;
            r_band   <= '0;
            r_tap    <= '0;
            r_gain   <= '0;
            r_held   <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_band   <= n_band;
            r_tap    <= n_tap;
            r_gain   <= n_gain;
            r_held   <= n_held;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_v1     <= n_v1;
            r_v2     <= r_v1;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_end    <= n_end;
        r_rp     <= n_rp;
        r_cnt    <= n_cnt;
        r_z1     <= n_z1;
        r_ofilt  <= n_ofilt;
        r_ofinal <= n_ofinal;
    end

    // coefficient memory
    assign coef_ra = (r_state == S_FMAC) ? r_cnt[AW-1:0] : tap_m1[AW-1:0];
    assign coef_wa = tap_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_wa] <= coef_wd;
        end
        r_coef_rd <= coef_mem[coef_ra];
    end

    // delay line memory, circular
    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            dl_mem[r_wp] <= r_word;
        end
        r_dl_rd <= dl_mem[r_rp];
    end

    // shared MAC
    assign mac_ctrl.mul_en  = (r_state == S_LMUL) || r_v1;
    assign mac_ctrl.acc_clr = (r_state == S_FWR);
    assign mac_ctrl.acc_add = r_v2;
    assign mac_a = (r_state == S_LMUL) ? r_gain : r_coef_rd;
    assign mac_b = (r_state == S_LMUL) ? r_word : (r_z1 ? '0 : r_dl_rd);

    bgeq_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    // handshake outputs
    assign i_in.ready      = (r_state == S_IN);
    assign o_out.valid     = r_ovalid;
    assign o_out.filtered  = r_ofilt;
    assign o_out.final_res = r_ofinal;

    // checks
    a_filter_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (r_phase == PH_FILTER) |=> (r_state == S_FWR))
        else $error("sample item did not start a filter sweep");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= TW'(TAPS))
        else $error("delay line fill count past tap count");

    a_acc_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_FMAC))
        else $error("accumulate outside the filter sweep");

    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && out_free |=>
            (r_phase == PH_IDLE) && (r_held == '0) && o_out.final_res)
        else $error("closing item did not end the run");

endmodule

@@ tb/band_gain_fir_equalizer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-gain FIR equalizer testbench
// Drives marker, gain, coefficient and sample items into the equalizer under
// random idling and back-pressure, predicts every filter and closing result
// with a cycle-free model of the stream protocol, and checks each result in
// order. Marker registers are rewritten between streams while the block idles.
// ----------------------------------------------------------------------------
module band_gain_fir_equalizer_top_tb;
    import bgeq_pkg::*;

    typedef enum logic [1:0] {EQ_IDLE, EQ_LOAD, EQ_WAIT, EQ_FILTER} eq_phase_t;

    typedef struct {
        logic [DW-1:0] filtered;
        logic          final_res;
    } fir_out_t;

    // Tracks the equalizer state and the results still owed by the block
    class equalizer_tracker;
        logic [DW-1:0] start_mk;
        logic [DW-1:0] filter_mk;
        eq_phase_t     phase;
        int            band_cnt;
        int            tap_idx;
        logic [DW-1:0] gain;
        logic [DW-1:0] coef [TAPS];
        logic [DW-1:0] line [TAPS];
        logic [DW-1:0] held;
        fir_out_t      pending_fir_out [$];
        int            errors;

        function new();
            start_mk  = 32'hBEEF;
            filter_mk = 32'hABBA;
            phase     = EQ_IDLE;
            band_cnt  = 0;
            tap_idx   = 0;
            gain      = '0;
            held      = '0;
            errors    = 0;
            foreach (coef[i]) coef[i] = '0;
            foreach (line[i]) line[i] = '0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        function int pending();
            return pending_fir_out.size();
        endfunction

        // One accepted item: advance the stream state, queue the results it causes
        function void accept_word(logic [DW-1:0] w, logic e);
            fir_out_t      r;
            logic [DW-1:0] acc;
            case (phase)
                EQ_IDLE: begin
                    if (w == start_mk) begin
                        foreach (coef[i]) coef[i] = '0;
                        band_cnt = 0;
                        tap_idx  = 0;
                        phase    = EQ_LOAD;
                    end
                end
                EQ_LOAD: begin
                    // end marks are ignored inside coefficient blocks
                    if (tap_idx == 0) begin
                        gain    = w;
                        tap_idx = 1;
                    end else begin
                        coef[tap_idx - 1] = coef[tap_idx - 1] + gain * w;
                        tap_idx++;
                        if (tap_idx > TAPS) begin
                            tap_idx = 0;
                            band_cnt++;
                            if (band_cnt >= BANDS) phase = EQ_WAIT;
                        end
                    end
                    return;
                end
                EQ_WAIT: begin
                    if (w == filter_mk) phase = EQ_FILTER;
                end
                default: begin
                    acc = '0;
                    for (int i = TAPS - 1; i > 0; i--) begin
                        line[i] = line[i - 1];
                        acc     = acc + line[i] * coef[i];
                    end
                    acc     = acc + w * coef[0];
                    line[0] = w;
                    held    = acc;
                    r.filtered  = acc;
                    r.final_res = 1'b0;
                    pending_fir_out.push_back(r);
                end
            endcase

            if (e) begin
                r.filtered  = held;
                r.final_res = 1'b1;
                pending_fir_out.push_back(r);
                held     = '0;
                phase    = EQ_IDLE;
                band_cnt = 0;
                tap_idx  = 0;
            end
        endfunction

        // One accepted result against the oldest one owed
        task match_output(logic [DW-1:0] f, logic fin);
            fir_out_t r;
            if (pending_fir_out.size() == 0) begin
                report($sformatf("unexpected result filtered=%h final=%b", f, fin));
                return;
            end
            r = pending_fir_out.pop_front();
            if (f !== r.filtered)
                report($sformatf("filtered %h, expected %h", f, r.filtered));
            if (fin !== r.final_res)
                report($sformatf("final_res %b, expected %b", fin, r.final_res));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bgeq_in_if  in_ch ();
    bgeq_out_if out_ch ();

    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [PAW-1:0]  paddr;
    logic [DW-1:0]   pwdata;
    logic [DW-1:0]   prdata;
    logic            pready;

    equalizer_tracker tracker;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int sent_items;
    int idle_mode;

    band_gain_fir_equalizer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Handshake monitor: inputs first, then results
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready)
                tracker.accept_word(in_ch.word, in_ch.end_mark);
            if (out_ch.valid && out_ch.ready)
                tracker.match_output(out_ch.filtered, out_ch.final_res);
        end
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task set_idle_mode(input int m);
        case (m)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    // Offer one item after a random gap, return at the edge that takes it
    task send_item(input logic [DW-1:0] w, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.word     <= w;
        in_ch.end_mark <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_items++;
        // rotate idling every 120 items
        if (sent_items % 120 == 0) begin
            idle_mode = (idle_mode + 1) % 4;
            set_idle_mode(idle_mode);
        end
    endtask

    // Drop valid, wait for every owed result, then wait on with valid low
    task settle();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (TAPS + 20) @(posedge i_clk);
    endtask

    task write_reg(input logic idx, input logic [DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START) tracker.start_mk = value;
        else                  tracker.filter_mk = value;
    endtask

    // Mix of extremes, small signed values and full-range words
    function automatic logic [DW-1:0] pick_word();
        logic [DW-1:0] w;
        case ($urandom_range(15))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2: w = 32'hFFFF_FFFF;
            3: w = 32'h0000_0000;
            4, 5, 6, 7, 8: begin
                w = $urandom_range(511);
                w = w - 256;
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic logic [DW-1:0] word_except(input logic [DW-1:0] v);
        logic [DW-1:0] w;
        w = $urandom;
        while (w == v) w = $urandom;
        return w;
    endfunction

    // BANDS gain + coefficient blocks, stray end marks included
    task load_bands();
        for (int b = 0; b < BANDS; b++) begin
            send_item(pick_word(), $urandom_range(7) == 0);
            for (int t = 0; t < TAPS; t++)
                send_item(pick_word(), $urandom_range(7) == 0);
        end
    endtask

    // One stream: idle noise, load, wait noise, then filter or an early end
    task run_stream(input bit end_in_wait, input bit squeeze);
        int n_samples;
        int ending;
        n_samples = $urandom_range(80, 250);
        ending    = $urandom_range(19);
        repeat ($urandom_range(3))
            send_item(word_except(tracker.start_mk), $urandom_range(3) == 0);
        send_item(tracker.start_mk, 1'b0);
        load_bands();
        repeat ($urandom_range(3))
            send_item(word_except(tracker.filter_mk), 1'b0);
        if (end_in_wait) begin
            send_item(word_except(tracker.filter_mk), 1'b1);
        end else if (ending == 0 && !squeeze) begin
            send_item(tracker.filter_mk, 1'b1);
        end else begin
            send_item(tracker.filter_mk, 1'b0);
            for (int k = 0; k < n_samples; k++) begin
                // long receiver hold-off so the block backs up into its input
                if (squeeze && k == 12) hold_request = 1000;
                send_item(pick_word(), k == n_samples - 1);
            end
        end
    endtask

    initial begin
        int run_no;
        logic [DW-1:0] smk;
        logic [DW-1:0] fmk;

        tracker        = new();
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.word     = '0;
        in_ch.end_mark = 1'b0;
        out_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_request   = 0;
        hold_left      = 0;
        sent_items     = 0;
        idle_mode      = 0;
        set_idle_mode(0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset markers, end in idle, start marker with end mark
        send_item(32'h0000_1234, 1'b1);
        send_item(32'h0000_BEEF, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        // full load, wrong words while waiting, extreme samples, end on a sample
        send_item(32'h0000_BEEF, 1'b0);
        load_bands();
        send_item(32'h0000_BEEF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_ABBA, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b1);

        // Random streams, new markers before each
        run_no = 0;
        while (sent_items < 1150) begin
            settle();
            case (run_no)
                0: begin smk = 32'h0000_0000; fmk = 32'hFFFF_FFFF; end
                1: begin smk = 32'hFFFF_FFFF; fmk = 32'h0000_0000; end
                default: begin smk = $urandom; fmk = $urandom; end
            endcase
            write_reg(REG_START, smk);
            write_reg(REG_FILTER, fmk);
            run_stream(run_no == 1, run_no == 0);
            run_no++;
        end

        settle();
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
